// ===== rtl/ipmc_pkg.sv =====
// Shared types and constants for the IMU peak motion capture block.
// No dependencies; used by every module under rtl/.
`default_nettype none

package ipmc_pkg;

  localparam int AXES   = 3;
  localparam int AXIS_W = 2;

  localparam int RAW_W = 16;
  localparam int ACC_W = 12;
  localparam int GYR_W = 10;
  localparam int MAG_W = 12;
  localparam int SUM_W = 24;

  // Shared multiplier operand and product widths
  localparam int MUL_A_W = 16;
  localparam int MUL_B_W = 14;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;

  // Accel scale: |raw| * 2000 / 32767, divide by 2^15 then correct by one
  localparam logic [MUL_B_W-1:0] ACCEL_NUM   = 14'd2000;
  localparam logic [RAW_W-1:0]   ACCEL_DEN   = 16'd32767;
  localparam int                 ACCEL_SHIFT = 15;
  localparam int                 ACC_PROD_W  = 26;

  // Gyro scale: |raw| * 7 / 800 = ((|raw| * 7) >> 5) * 10486 >> 18
  localparam logic [MUL_B_W-1:0] GYRO_NUM        = 14'd7;
  localparam logic [MUL_B_W-1:0] GYRO_RECIP      = 14'd10486;
  localparam int                 GYRO_PRE_SHIFT  = 5;
  localparam int                 GYRO_PRE_W      = 18;
  localparam int                 GYRO_POST_SHIFT = 18;

  // Largest magnitude: floor(sqrt(3 * 2000^2))
  localparam logic [MAG_W-1:0] MAG_MAX = 12'd3464;

  localparam int SQRT_STEPS = SUM_W / 2;
  localparam int SQRT_CNT_W = $clog2(SQRT_STEPS);

  typedef struct packed {
    logic               en;
    logic [MUL_A_W-1:0] a;
    logic [MUL_B_W-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic             start;
    logic [SUM_W-1:0] radicand;
  } sqrt_req_t;

  typedef struct packed {
    logic             done;
    logic [MAG_W-1:0] root;
  } sqrt_rsp_t;

endpackage

`default_nettype wire

// ===== rtl/ipmc_mul.sv =====
// Shared unsigned multiplier with registered product.
// Depends on ipmc_pkg.
`default_nettype none

module ipmc_mul (
  input  wire logic                       clk,
  input  wire ipmc_pkg::mul_req_t         req,
  output logic [ipmc_pkg::PROD_W-1:0]     prod
);

  always_ff @(posedge clk) begin
    if (req.en) begin
      prod <= {{(ipmc_pkg::PROD_W - ipmc_pkg::MUL_A_W){1'b0}}, req.a} *
              {{(ipmc_pkg::PROD_W - ipmc_pkg::MUL_B_W){1'b0}}, req.b};
    end
  end

endmodule

`default_nettype wire

// ===== rtl/ipmc_isqrt.sv =====
// Iterative integer square root, two radicand bits per cycle.
// Depends on ipmc_pkg.
`default_nettype none

module ipmc_isqrt (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire ipmc_pkg::sqrt_req_t  req,
  output ipmc_pkg::sqrt_rsp_t       rsp
);

  logic                                busy;
  logic                                done;
  logic [ipmc_pkg::SQRT_CNT_W-1:0]     cnt;
  logic [ipmc_pkg::SUM_W-1:0]          rad;
  logic [ipmc_pkg::MAG_W:0]            rem;
  logic [ipmc_pkg::MAG_W-1:0]          root;

  logic [ipmc_pkg::MAG_W+2:0]          rem_sh;
  logic [ipmc_pkg::MAG_W+2:0]          trial;
  logic [ipmc_pkg::MAG_W+2:0]          diff;
  logic                                take;

  always_comb begin
    rem_sh = {rem, rad[ipmc_pkg::SUM_W-1 -: 2]};
    trial  = {1'b0, root, 2'b01};
    take   = (rem_sh >= trial);
    diff   = rem_sh - trial;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      // Flag the last step; the root is complete on the following cycle
      done <= busy && !req.start &&
              (cnt == ipmc_pkg::SQRT_CNT_W'(ipmc_pkg::SQRT_STEPS - 1));
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
        rad  <= req.radicand;
        rem  <= '0;
        root <= '0;
      end else if (busy) begin
        rad  <= rad << 2;
        rem  <= take ? diff[ipmc_pkg::MAG_W:0] : rem_sh[ipmc_pkg::MAG_W:0];
        root <= {root[ipmc_pkg::MAG_W-2:0], take};
        cnt  <= cnt + ipmc_pkg::SQRT_CNT_W'(1);
        if (cnt == ipmc_pkg::SQRT_CNT_W'(ipmc_pkg::SQRT_STEPS - 1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.root = root;

endmodule

`default_nettype wire

// ===== rtl/imu_peak_motion_capture_unit.sv =====
// Top level of the IMU peak motion capture block: sequencer, held peak.
// Depends on ipmc_pkg, ipmc_mul and ipmc_isqrt.
//
// Use: the input channel (in_valid/in_ready) carries one word per sensor
// sample or report request. op = 0 is a motion sample: all six raw words
// are scaled (accel to milli-g, gyro to deg/s), the accel magnitude is
// taken as an exact integer square root, and a strictly larger magnitude
// latches the six scaled values as the new peak. A sample gives no result.
// op = 1 is a report: the latched six values go out as one word on the
// output channel (out_valid/out_ready) and the peak clears to zero.
// A sample holds in_ready low until the sequencer is idle again, so the block
// takes no new sample before the last is through: one shared multiplier
// stepped over the six axes, then the square root (a start state, 12 steps
// of two radicand bits, and a done flag). A report's word shows on the
// outputs the cycle after the report is accepted.
// A report waits while an earlier report word is still untaken; samples
// are taken meanwhile, so a stalled receiver only blocks reports.
// Reset (rst, synchronous) clears the held peak to zero, drops any pending
// output word and returns the sequencer to idle.
`default_nettype none

module imu_peak_motion_capture_unit (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic                                op,
  input  wire logic signed [ipmc_pkg::RAW_W-1:0]   accel_x_raw,
  input  wire logic signed [ipmc_pkg::RAW_W-1:0]   accel_y_raw,
  input  wire logic signed [ipmc_pkg::RAW_W-1:0]   accel_z_raw,
  input  wire logic signed [ipmc_pkg::RAW_W-1:0]   gyro_x_raw,
  input  wire logic signed [ipmc_pkg::RAW_W-1:0]   gyro_y_raw,
  input  wire logic signed [ipmc_pkg::RAW_W-1:0]   gyro_z_raw,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic signed [ipmc_pkg::ACC_W-1:0]        peak_accel_x,
  output logic signed [ipmc_pkg::ACC_W-1:0]        peak_accel_y,
  output logic signed [ipmc_pkg::ACC_W-1:0]        peak_accel_z,
  output logic signed [ipmc_pkg::GYR_W-1:0]        peak_gyro_x,
  output logic signed [ipmc_pkg::GYR_W-1:0]        peak_gyro_y,
  output logic signed [ipmc_pkg::GYR_W-1:0]        peak_gyro_z
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_ACC_MUL,
    S_ACC_DIV,
    S_ACC_SQ,
    S_ACC_ADD,
    S_GYR_MUL,
    S_GYR_REC,
    S_GYR_DIV,
    S_ROOT_START,
    S_ROOT_WAIT
  } state_t;

  state_t                               state;
  logic [ipmc_pkg::AXIS_W-1:0]          axis;

  // Captured raw words of the sample in flight
  logic [ipmc_pkg::RAW_W-1:0]           raw_acc [ipmc_pkg::AXES];
  logic [ipmc_pkg::RAW_W-1:0]           raw_gyr [ipmc_pkg::AXES];

  // Scaled values of the sample in flight
  logic signed [ipmc_pkg::ACC_W-1:0]    acc [ipmc_pkg::AXES];
  logic signed [ipmc_pkg::GYR_W-1:0]    gyr [ipmc_pkg::AXES];
  logic [ipmc_pkg::ACC_W-2:0]           amag;
  logic [ipmc_pkg::SUM_W-1:0]           sum;

  // Held peak
  logic signed [ipmc_pkg::ACC_W-1:0]    held_accel [ipmc_pkg::AXES];
  logic signed [ipmc_pkg::GYR_W-1:0]    held_gyro  [ipmc_pkg::AXES];
  logic [ipmc_pkg::MAG_W-1:0]           held_magnitude;

  ipmc_pkg::mul_req_t                   mul_req;
  logic [ipmc_pkg::PROD_W-1:0]          prod;
  ipmc_pkg::sqrt_req_t                  sq_req;
  ipmc_pkg::sqrt_rsp_t                  sq_rsp;

  logic                                 accept;
  logic [ipmc_pkg::RAW_W-1:0]           acc_raw_sel;
  logic [ipmc_pkg::RAW_W-1:0]           gyr_raw_sel;
  logic [ipmc_pkg::ACC_W-2:0]           acc_q0;
  logic [ipmc_pkg::RAW_W-1:0]           acc_rsum;
  logic [ipmc_pkg::ACC_W-2:0]           acc_q;
  logic signed [ipmc_pkg::ACC_W-1:0]    acc_val;
  logic [ipmc_pkg::GYR_W-2:0]           gyr_q;
  logic signed [ipmc_pkg::GYR_W-1:0]    gyr_val;

  function automatic logic [ipmc_pkg::RAW_W-1:0] mag_of(
    input logic [ipmc_pkg::RAW_W-1:0] v
  );
    return v[ipmc_pkg::RAW_W-1] ? (~v + ipmc_pkg::RAW_W'(1)) : v;
  endfunction

  // Reports need the output register free (or emptying); samples do not.
  assign in_ready = (state == S_IDLE) && (!out_valid || out_ready || !op);
  assign accept   = in_valid && in_ready;

  assign acc_raw_sel = raw_acc[axis];
  assign gyr_raw_sel = raw_gyr[axis];

  // Accel divide by 32767: take >> 15, then add one when the remainder
  // p - q0*32767 = p[14:0] + q0 reaches the divisor.
  always_comb begin
    acc_q0   = prod[ipmc_pkg::ACC_PROD_W-1:ipmc_pkg::ACCEL_SHIFT];
    acc_rsum = {1'b0, prod[ipmc_pkg::ACCEL_SHIFT-1:0]} +
               ipmc_pkg::RAW_W'(acc_q0);
    acc_q    = acc_q0 + (ipmc_pkg::ACC_W-1)'(acc_rsum >= ipmc_pkg::ACCEL_DEN);
    acc_val  = acc_raw_sel[ipmc_pkg::RAW_W-1] ? -$signed({1'b0, acc_q})
                                              :  $signed({1'b0, acc_q});
    gyr_q    = prod[ipmc_pkg::GYRO_POST_SHIFT+ipmc_pkg::GYR_W-2:ipmc_pkg::GYRO_POST_SHIFT];
    gyr_val  = gyr_raw_sel[ipmc_pkg::RAW_W-1] ? -$signed({1'b0, gyr_q})
                                              :  $signed({1'b0, gyr_q});
  end

  // Multiplier operand select
  always_comb begin
    mul_req = '0;
    unique case (state)
      S_ACC_MUL: begin
        mul_req.en = 1'b1;
        mul_req.a  = mag_of(acc_raw_sel);
        mul_req.b  = ipmc_pkg::ACCEL_NUM;
      end
      S_ACC_SQ: begin
        mul_req.en = 1'b1;
        mul_req.a  = ipmc_pkg::MUL_A_W'(amag);
        mul_req.b  = ipmc_pkg::MUL_B_W'(amag);
      end
      S_GYR_MUL: begin
        mul_req.en = 1'b1;
        mul_req.a  = mag_of(gyr_raw_sel);
        mul_req.b  = ipmc_pkg::GYRO_NUM;
      end
      S_GYR_REC: begin
        mul_req.en = 1'b1;
        mul_req.a  = ipmc_pkg::MUL_A_W'(
                       prod[ipmc_pkg::GYRO_PRE_W-1:ipmc_pkg::GYRO_PRE_SHIFT]);
        mul_req.b  = ipmc_pkg::GYRO_RECIP;
      end
      default: begin
        mul_req = '0;
      end
    endcase
  end

  assign sq_req.start    = (state == S_ROOT_START);
  assign sq_req.radicand = sum;

  ipmc_mul u_mul (
    .clk  (clk),
    .req  (mul_req),
    .prod (prod)
  );

  ipmc_isqrt u_isqrt (
    .clk (clk),
    .rst (rst),
    .req (sq_req),
    .rsp (sq_rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      out_valid      <= 1'b0;
      held_magnitude <= '0;
      for (int i = 0; i < ipmc_pkg::AXES; i++) begin
        held_accel[i] <= '0;
        held_gyro[i]  <= '0;
      end
    end else begin
      // Drop the output word once taken, unless a report refills it
      if (out_valid && out_ready && !(accept && op)) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (op) begin
              // Report: emit held peak, clear it
              out_valid      <= 1'b1;
              peak_accel_x   <= held_accel[0];
              peak_accel_y   <= held_accel[1];
              peak_accel_z   <= held_accel[2];
              peak_gyro_x    <= held_gyro[0];
              peak_gyro_y    <= held_gyro[1];
              peak_gyro_z    <= held_gyro[2];
              held_magnitude <= '0;
              for (int i = 0; i < ipmc_pkg::AXES; i++) begin
                held_accel[i] <= '0;
                held_gyro[i]  <= '0;
              end
            end else begin
              raw_acc[0] <= accel_x_raw;
              raw_acc[1] <= accel_y_raw;
              raw_acc[2] <= accel_z_raw;
              raw_gyr[0] <= gyro_x_raw;
              raw_gyr[1] <= gyro_y_raw;
              raw_gyr[2] <= gyro_z_raw;
              axis       <= '0;
              sum        <= '0;
              state      <= S_ACC_MUL;
            end
          end
        end
        S_ACC_MUL: begin
          state <= S_ACC_DIV;
        end
        S_ACC_DIV: begin
          acc[axis] <= acc_val;
          amag      <= acc_q;
          state     <= S_ACC_SQ;
        end
        S_ACC_SQ: begin
          state <= S_ACC_ADD;
        end
        S_ACC_ADD: begin
          sum <= sum + ipmc_pkg::SUM_W'(prod[2*(ipmc_pkg::ACC_W-1)-1:0]);
          if (axis == ipmc_pkg::AXIS_W'(ipmc_pkg::AXES - 1)) begin
            axis  <= '0;
            state <= S_GYR_MUL;
          end else begin
            axis  <= axis + ipmc_pkg::AXIS_W'(1);
            state <= S_ACC_MUL;
          end
        end
        S_GYR_MUL: begin
          state <= S_GYR_REC;
        end
        S_GYR_REC: begin
          state <= S_GYR_DIV;
        end
        S_GYR_DIV: begin
          gyr[axis] <= gyr_val;
          if (axis == ipmc_pkg::AXIS_W'(ipmc_pkg::AXES - 1)) begin
            state <= S_ROOT_START;
          end else begin
            axis  <= axis + ipmc_pkg::AXIS_W'(1);
            state <= S_GYR_MUL;
          end
        end
        S_ROOT_START: begin
          state <= S_ROOT_WAIT;
        end
        S_ROOT_WAIT: begin
          if (sq_rsp.done) begin
            // Strictly larger magnitude replaces the peak
            if (sq_rsp.root > held_magnitude) begin
              held_magnitude <= sq_rsp.root;
              for (int i = 0; i < ipmc_pkg::AXES; i++) begin
                held_accel[i] <= acc[i];
                held_gyro[i]  <= gyr[i];
              end
            end
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_report_clears: assert property (@(posedge clk) disable iff (rst)
    (accept && op) |=> (out_valid && held_magnitude == '0))
    else $error("report did not raise out_valid and clear the peak");

  a_root_in_wait: assert property (@(posedge clk) disable iff (rst)
    sq_rsp.done |-> (state == S_ROOT_WAIT))
    else $error("square root finished outside the wait state");

  a_sample_starts: assert property (@(posedge clk) disable iff (rst)
    (accept && !op) |=> (state == S_ACC_MUL && sum == '0 && axis == '0))
    else $error("sample did not start the sequencer cleanly");

  a_mag_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_ROOT_WAIT && sq_rsp.done) |-> (sq_rsp.root <= ipmc_pkg::MAG_MAX))
    else $error("magnitude beyond the scaled accel range");
`endif

endmodule

`default_nettype wire
